/* sv/whp_pkg.sv */
package whp_pkg;

   // width of the byte position counter, 16 to 32
   localparam int OFFSET_BITS = 32;

   typedef logic [OFFSET_BITS-1:0] pos_type;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam int MAGIC_LEN = 12;
   localparam logic [31:0] FMT_MIN = 32'd16;
   localparam logic [3:0] BITS_AT = 4'd14;
   localparam logic [32:0] HDR_LEN = 33'd8;

   localparam pos_type POS_MAX = '1;
   localparam pos_type POS_RIFF_END = pos_type'(3);
   localparam pos_type POS_WAVE_END = pos_type'(MAGIC_LEN - 1);

   typedef enum logic [3:0] {
      ST_OK,
      ST_SHORT,
      ST_MAGIC,
      ST_OVERRUN,
      ST_FMT_SHORT,
      ST_NO_FMT,
      ST_NO_DATA,
      ST_UNSUPPORTED,
      ST_DATA_SMALL
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [1:0]  channel_count;
      logic [31:0] rate_hz;
      logic [31:0] data_start;
      logic [30:0] frame_total;
   } result_type;

endpackage

/* sv/wav_header_parser.sv */
// wav header parser: one file byte per request, one result per file
// a final byte passes the input register and then the result register before rsp_valid
// throughput: one byte per cycle; only a final byte waits, while the
// result register is full and stalled
// reset (synchronous, active high) empties both registers and restarts
// parsing at the magic check; every final byte also restarts it
module wav_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_file_byte,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic [1:0]  rsp_channel_count,
   output logic [31:0] rsp_rate_hz,
   output logic [31:0] rsp_data_start,
   output logic [30:0] rsp_frame_total
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_last_ff;
   logic                advance;
   logic                out_free;
   logic                res_load;
   whp_pkg::result_type result;
   whp_pkg::result_type rsp_result;

   // a non-final byte never needs the result register
   assign advance     = in_valid_ff && (!in_last_ff || out_free);
   assign res_load    = advance && in_last_ff;
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_file_byte;
         in_last_ff <= req_is_last;
      end
   end

   whp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .file_byte (in_byte_ff),
      .is_last   (in_last_ff),
      .result    (result)
   );

   whp_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (res_load),
      .result     (result),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result),
      .free       (out_free)
   );

   assign rsp_status        = rsp_result.status;
   assign rsp_channel_count = rsp_result.channel_count;
   assign rsp_rate_hz       = rsp_result.rate_hz;
   assign rsp_data_start    = rsp_result.data_start;
   assign rsp_frame_total   = rsp_result.frame_total;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall && res_load))
      else $error("result register overwritten while stalled");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_last_ff))
      else $error("request stalled without a pending final byte");

   a_ok_channels: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == whp_pkg::ST_OK) |->
      (rsp_channel_count == 2'd1 || rsp_channel_count == 2'd2))
      else $error("ok result with bad channel count");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != whp_pkg::ST_OK) |->
      (rsp_channel_count == 2'd0 && rsp_rate_hz == 32'd0 &&
       rsp_data_start == 32'd0 && rsp_frame_total == 31'd0))
      else $error("error result carries nonzero fields");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      res_load |=> rsp_valid)
      else $error("loaded result not presented");
`endif

endmodule

/* sv/whp_parser.sv */
module whp_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          file_byte,
   input  logic                is_last,
   output whp_pkg::result_type result
);

   typedef enum logic [2:0] {
      PH_MAGIC,
      PH_HDR,
      PH_BODY,
      PH_BADFMT,
      PH_DONE
   } phase_type;

   phase_type           phase_ff, phase_in;
   whp_pkg::pos_type    pos_ff, pos_in;
   logic [31:0]         hdr_ff, hdr_in;
   logic [31:0]         len_ff, len_in;
   logic [32:0]         left_ff, left_in;
   logic                is_fmt_ff, is_fmt_in;
   logic                fmt_seen_ff, fmt_seen_in;
   logic                data_seen_ff, data_seen_in;
   logic [15:0]         fmt_tag_ff, fmt_tag_in;
   logic [15:0]         chan_ff, chan_in;
   logic [31:0]         rate_ff, rate_in;
   logic [15:0]         bits_ff, bits_in;
   logic [31:0]         doff_ff, doff_in;
   logic [31:0]         dsize_ff, dsize_in;
   whp_pkg::status_type err_ff, err_in;

   logic [32:0]         left_dec;
   logic [32:0]         body_at;
   logic [3:0]          lane;
   whp_pkg::status_type status;
   logic                chan_ok;

   assign pos_in   = (pos_ff == whp_pkg::POS_MAX) ? pos_ff : pos_ff + whp_pkg::pos_type'(1);
   assign left_dec = left_ff - 33'd1;
   // offset of the current byte inside the chunk body
   assign body_at  = {1'b0, len_ff} + 33'(len_ff[0]) - left_ff;
   assign lane     = body_at[3:0];

   always_comb begin
      phase_in     = phase_ff;
      hdr_in       = hdr_ff;
      len_in       = len_ff;
      left_in      = left_ff;
      is_fmt_in    = is_fmt_ff;
      fmt_seen_in  = fmt_seen_ff;
      data_seen_in = data_seen_ff;
      fmt_tag_in   = fmt_tag_ff;
      chan_in      = chan_ff;
      rate_in      = rate_ff;
      bits_in      = bits_ff;
      doff_in      = doff_ff;
      dsize_in     = dsize_ff;
      err_in       = err_ff;
      unique case (phase_ff)
         PH_MAGIC: begin
            hdr_in = {file_byte, hdr_ff[31:8]};
            if (pos_ff == whp_pkg::POS_RIFF_END && hdr_in != whp_pkg::TAG_RIFF &&
                err_ff == whp_pkg::ST_OK) begin
               err_in = whp_pkg::ST_MAGIC;
            end
            if (pos_ff == whp_pkg::POS_WAVE_END) begin
               if (hdr_in != whp_pkg::TAG_WAVE && err_in == whp_pkg::ST_OK) begin
                  err_in = whp_pkg::ST_MAGIC;
               end
               if (err_in != whp_pkg::ST_OK) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_HDR;
                  left_in  = whp_pkg::HDR_LEN;
               end
            end
         end
         PH_HDR: begin
            // id bytes first, then the little-endian size
            if (left_ff > 33'd4) begin
               hdr_in = {file_byte, hdr_ff[31:8]};
            end else begin
               len_in = {file_byte, len_ff[31:8]};
            end
            left_in = left_dec;
            if (left_dec == 33'd0) begin
               is_fmt_in = (hdr_in == whp_pkg::TAG_FMT);
               left_in   = {1'b0, len_in} + 33'(len_in[0]);
               phase_in  = PH_BODY;
               if (is_fmt_in) begin
                  if (len_in < whp_pkg::FMT_MIN) begin
                     if (len_in == 32'd0) begin
                        err_in   = whp_pkg::ST_FMT_SHORT;
                        phase_in = PH_DONE;
                     end else begin
                        phase_in = PH_BADFMT;
                     end
                  end else begin
                     fmt_seen_in = 1'b1;
                  end
               end else if (hdr_in == whp_pkg::TAG_DATA) begin
                  doff_in      = 32'(pos_in);
                  dsize_in     = len_in;
                  data_seen_in = 1'b1;
               end
               // an empty chunk other than fmt goes straight to the next header
               if (!is_fmt_in && len_in == 32'd0) begin
                  phase_in = PH_HDR;
                  left_in  = whp_pkg::HDR_LEN;
               end
            end
         end
         PH_BODY: begin
            if (is_fmt_ff && body_at < 33'(whp_pkg::FMT_MIN)) begin
               unique case (lane)
                  4'd0:    fmt_tag_in[7:0]  = file_byte;
                  4'd1:    fmt_tag_in[15:8] = file_byte;
                  4'd2:    chan_in[7:0]     = file_byte;
                  4'd3:    chan_in[15:8]    = file_byte;
                  4'd4:    rate_in[7:0]     = file_byte;
                  4'd5:    rate_in[15:8]    = file_byte;
                  4'd6:    rate_in[23:16]   = file_byte;
                  4'd7:    rate_in[31:24]   = file_byte;
                  whp_pkg::BITS_AT:        bits_in[7:0]  = file_byte;
                  whp_pkg::BITS_AT + 4'd1: bits_in[15:8] = file_byte;
                  default: ;
               endcase
            end
            left_in = left_dec;
            if (left_dec == 33'd0) begin
               phase_in = PH_HDR;
               left_in  = whp_pkg::HDR_LEN;
            end
         end
         PH_BADFMT: begin
            left_in = left_dec;
            if (left_dec <= 33'(len_ff[0])) begin
               err_in   = whp_pkg::ST_FMT_SHORT;
               phase_in = PH_DONE;
            end
         end
         PH_DONE: ;
         default: ;
      endcase
   end

   assign chan_ok = (chan_in == 16'd1) || (chan_in == 16'd2);

   always_comb begin
      priority if (phase_in == PH_MAGIC) begin
         status = whp_pkg::ST_SHORT;
      end else if (err_in != whp_pkg::ST_OK) begin
         status = err_in;
      end else if ((phase_in == PH_BODY || phase_in == PH_BADFMT) &&
                   left_in > 33'(len_in[0])) begin
         status = whp_pkg::ST_OVERRUN;
      end else if (!fmt_seen_in) begin
         status = whp_pkg::ST_NO_FMT;
      end else if (!data_seen_in) begin
         status = whp_pkg::ST_NO_DATA;
      end else if (fmt_tag_in != 16'd1 || !chan_ok || bits_in != 16'd16) begin
         status = whp_pkg::ST_UNSUPPORTED;
      end else if (dsize_in < {13'd0, chan_in, 3'd0} >> 2) begin
         status = whp_pkg::ST_DATA_SMALL;
      end else begin
         status = whp_pkg::ST_OK;
      end
   end

   always_comb begin
      result.status = status;
      if (status == whp_pkg::ST_OK) begin
         result.channel_count = chan_in[1:0];
         result.rate_hz       = rate_in;
         result.data_start    = doff_in;
         result.frame_total   = (chan_in == 16'd2) ? {1'b0, dsize_in[31:2]} : dsize_in[31:1];
      end else begin
         result.channel_count = 2'd0;
         result.rate_hz       = 32'd0;
         result.data_start    = 32'd0;
         result.frame_total   = 31'd0;
      end
   end

   always_ff @(posedge clock) begin
      // the final byte of a file leaves the parser ready for the next one
      if (reset || (step && is_last)) begin
         phase_ff     <= PH_MAGIC;
         pos_ff       <= '0;
         hdr_ff       <= '0;
         len_ff       <= '0;
         left_ff      <= '0;
         is_fmt_ff    <= 1'b0;
         fmt_seen_ff  <= 1'b0;
         data_seen_ff <= 1'b0;
         fmt_tag_ff   <= '0;
         chan_ff      <= '0;
         rate_ff      <= '0;
         bits_ff      <= '0;
         doff_ff      <= '0;
         dsize_ff     <= '0;
         err_ff       <= whp_pkg::ST_OK;
      end else if (step) begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         hdr_ff       <= hdr_in;
         len_ff       <= len_in;
         left_ff      <= left_in;
         is_fmt_ff    <= is_fmt_in;
         fmt_seen_ff  <= fmt_seen_in;
         data_seen_ff <= data_seen_in;
         fmt_tag_ff   <= fmt_tag_in;
         chan_ff      <= chan_in;
         rate_ff      <= rate_in;
         bits_ff      <= bits_in;
         doff_ff      <= doff_in;
         dsize_ff     <= dsize_in;
         err_ff       <= err_in;
      end
   end

endmodule

/* sv/whp_rsp_reg.sv */
module whp_rsp_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  whp_pkg::result_type result,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output whp_pkg::result_type rsp_result,
   output logic                free
);

   logic                valid_ff, valid_in;
   whp_pkg::result_type result_ff;

   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

/* dv/wav_header_checker.sv */
module wav_header_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_file_byte,
   input  logic        req_is_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [3:0]  rsp_status,
   input  logic [1:0]  rsp_channel_count,
   input  logic [31:0] rsp_rate_hz,
   input  logic [31:0] rsp_data_start,
   input  logic [30:0] rsp_frame_total,
   output int          error_count,
   output int          results_owed
);

   typedef enum logic [2:0] {
      WALK_MAGIC,
      WALK_HEADER,
      WALK_BODY,
      WALK_BAD_FMT,
      WALK_DONE
   } walk_type;

   localparam logic [32:0] POS_LIMIT = 33'(whp_pkg::POS_MAX);

   logic [32:0]         byte_at;
   walk_type            walk;
   logic [31:0]         tag_shift;
   logic [31:0]         chunk_len;
   logic [32:0]         chunk_left;
   logic                in_fmt;
   logic                fmt_found;
   logic                data_found;
   logic [15:0]         fmt_code;
   logic [15:0]         chan_num;
   logic [15:0]         bits_num;
   logic [31:0]         rate_val;
   logic [31:0]         data_off;
   logic [31:0]         data_len;
   whp_pkg::status_type first_err;

   whp_pkg::result_type owed_results[$];

   function automatic void restart_parse();
      byte_at = '0;
      walk = WALK_MAGIC;
      tag_shift = '0;
      chunk_len = '0;
      chunk_left = '0;
      in_fmt = 1'b0;
      fmt_found = 1'b0;
      data_found = 1'b0;
      fmt_code = '0;
      chan_num = '0;
      bits_num = '0;
      rate_val = '0;
      data_off = '0;
      data_len = '0;
      first_err = whp_pkg::ST_OK;
   endfunction

   // chunk id and size are in, decide what the body means
   function automatic void close_header(logic [32:0] next_at);
      in_fmt = (tag_shift == whp_pkg::TAG_FMT);
      chunk_left = {1'b0, chunk_len} + 33'(chunk_len[0]);
      walk = WALK_BODY;
      if (in_fmt) begin
         if (chunk_len < whp_pkg::FMT_MIN) begin
            if (chunk_len == 32'd0) begin
               first_err = whp_pkg::ST_FMT_SHORT;
               walk = WALK_DONE;
               return;
            end
            walk = WALK_BAD_FMT;
         end else begin
            fmt_found = 1'b1;
         end
      end else if (tag_shift == whp_pkg::TAG_DATA) begin
         data_off = next_at[31:0];
         data_len = chunk_len;
         data_found = 1'b1;
      end
      if (chunk_left == 33'd0) begin
         walk = WALK_HEADER;
         chunk_left = whp_pkg::HDR_LEN;
      end
   endfunction

   function automatic void eat_byte(logic [7:0] b, logic [32:0] at, logic [32:0] next_at);
      logic [32:0] offs;
      logic [3:0]  lane;
      logic        pad;
      pad = chunk_len[0];
      case (walk)
         WALK_MAGIC: begin
            tag_shift = {b, tag_shift[31:8]};
            if (at == 33'(whp_pkg::POS_RIFF_END) && tag_shift != whp_pkg::TAG_RIFF &&
                first_err == whp_pkg::ST_OK)
               first_err = whp_pkg::ST_MAGIC;
            if (at == 33'(whp_pkg::POS_WAVE_END)) begin
               if (tag_shift != whp_pkg::TAG_WAVE && first_err == whp_pkg::ST_OK)
                  first_err = whp_pkg::ST_MAGIC;
               if (first_err != whp_pkg::ST_OK) begin
                  walk = WALK_DONE;
               end else begin
                  walk = WALK_HEADER;
                  chunk_left = whp_pkg::HDR_LEN;
               end
            end
         end
         WALK_HEADER: begin
            if (chunk_left > 33'd4)
               tag_shift = {b, tag_shift[31:8]};
            else
               chunk_len = {b, chunk_len[31:8]};
            chunk_left = chunk_left - 33'd1;
            if (chunk_left == 33'd0)
               close_header(next_at);
         end
         WALK_BODY: begin
            offs = {1'b0, chunk_len} + 33'(pad) - chunk_left;
            if (in_fmt && offs < 33'd16) begin
               lane = offs[3:0];
               // bytes 8..13 are byte rate and block align, not kept
               if (lane < 4'd2)
                  fmt_code[8*lane[0] +: 8] = b;
               else if (lane < 4'd4)
                  chan_num[8*lane[0] +: 8] = b;
               else if (lane < 4'd8)
                  rate_val[8*lane[1:0] +: 8] = b;
               else if (lane >= whp_pkg::BITS_AT)
                  bits_num[8*lane[0] +: 8] = b;
            end
            chunk_left = chunk_left - 33'd1;
            if (chunk_left == 33'd0) begin
               walk = WALK_HEADER;
               chunk_left = whp_pkg::HDR_LEN;
            end
         end
         WALK_BAD_FMT: begin
            chunk_left = chunk_left - 33'd1;
            if (chunk_left <= {32'd0, pad}) begin
               first_err = whp_pkg::ST_FMT_SHORT;
               walk = WALK_DONE;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic whp_pkg::status_type file_verdict();
      if (walk == WALK_MAGIC)
         return whp_pkg::ST_SHORT;
      if (first_err != whp_pkg::ST_OK)
         return first_err;
      // a missing pad byte alone is not an overrun
      if ((walk == WALK_BODY || walk == WALK_BAD_FMT) && chunk_left > {32'd0, chunk_len[0]})
         return whp_pkg::ST_OVERRUN;
      if (!fmt_found)
         return whp_pkg::ST_NO_FMT;
      if (!data_found)
         return whp_pkg::ST_NO_DATA;
      if (fmt_code != 16'd1 || (chan_num != 16'd1 && chan_num != 16'd2) || bits_num != 16'd16)
         return whp_pkg::ST_UNSUPPORTED;
      if (data_len < {15'd0, chan_num, 1'b0})
         return whp_pkg::ST_DATA_SMALL;
      return whp_pkg::ST_OK;
   endfunction

   function automatic void parse_request(logic [7:0] b, logic last);
      logic [32:0]         at;
      logic [32:0]         next_at;
      whp_pkg::result_type res;
      at = byte_at;
      next_at = (at < POS_LIMIT) ? at + 33'd1 : POS_LIMIT;
      eat_byte(b, at, next_at);
      byte_at = next_at;
      if (last) begin
         res = '0;
         res.status = file_verdict();
         if (res.status == whp_pkg::ST_OK) begin
            res.channel_count = chan_num[1:0];
            res.rate_hz = rate_val;
            res.data_start = data_off & POS_LIMIT[31:0];
            res.frame_total = (chan_num == 16'd2) ? 31'(data_len >> 2) : 31'(data_len >> 1);
         end
         owed_results.push_back(res);
         restart_parse();
      end
   endfunction

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      $display("mismatch on %s at %0t: expected %0h, got %0h", what, $time, want, got);
      error_count++;
   endtask

   task automatic compare_result();
      whp_pkg::result_type want;
      if (owed_results.size() == 0) begin
         report_mismatch("unexpected rsp_status", 32'd0, 32'(rsp_status));
         return;
      end
      want = owed_results.pop_front();
      if (rsp_status != want.status)
         report_mismatch("rsp_status", 32'(want.status), 32'(rsp_status));
      if (rsp_channel_count != want.channel_count)
         report_mismatch("rsp_channel_count", 32'(want.channel_count), 32'(rsp_channel_count));
      if (rsp_rate_hz != want.rate_hz)
         report_mismatch("rsp_rate_hz", want.rate_hz, rsp_rate_hz);
      if (rsp_data_start != want.data_start)
         report_mismatch("rsp_data_start", want.data_start, rsp_data_start);
      if (rsp_frame_total != want.frame_total)
         report_mismatch("rsp_frame_total", 32'(want.frame_total), 32'(rsp_frame_total));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         owed_results.delete();
         restart_parse();
         error_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            compare_result();
         if (req_valid && !req_stall)
            parse_request(req_file_byte, req_is_last);
      end
      results_owed <= owed_results.size();
   end

endmodule

/* dv/tb_wav_header_parser.sv */
module tb_wav_header_parser;

   localparam int IDLE_LIMIT = 2000;
   localparam int BYTE_TARGET = 1300;

   typedef enum {
      WF_GOOD,
      WF_CUT,
      WF_BAD_MAGIC,
      WF_FMT_SHORT,
      WF_NO_FMT,
      WF_NO_DATA,
      WF_UNSUPPORTED,
      WF_DATA_SMALL,
      WF_PAD_GONE,
      WF_NOISE
   } file_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_file_byte = 8'd0;
   logic        req_is_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_status;
   logic [1:0]  rsp_channel_count;
   logic [31:0] rsp_rate_hz;
   logic [31:0] rsp_data_start;
   logic [30:0] rsp_frame_total;

   int          error_count;
   int          results_owed;

   logic [7:0]  file_bytes[$];
   int          burst_left = 0;
   logic        no_gaps = 1'b0;
   int          bytes_sent = 0;
   int          files_sent = 0;
   int          idle_cycles = 0;
   logic [9:0]  stall_clock = '0;
   int          stall_run = 0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   wav_header_parser dut (.*);

   wav_header_checker u_checker (.*);

   // receiver stall pattern is chosen by the top two bits of stall_clock
   always @(posedge clock) begin
      stall_clock <= stall_clock + 10'd1;
      case (stall_clock[9:8])
         2'd0: rsp_stall <= 1'b0;
         2'd1: rsp_stall <= ($urandom_range(0, 1) == 1);
         2'd2: begin
            if (stall_run != 0) begin
               rsp_stall <= 1'b1;
               stall_run <= stall_run - 1;
            end else if ($urandom_range(0, 9) == 0) begin
               rsp_stall <= 1'b1;
               stall_run <= $urandom_range(1, 30);
            end else begin
               rsp_stall <= 1'b0;
            end
         end
         default: rsp_stall <= (stall_clock[1:0] == 2'd0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic void add_word(logic [31:0] w, int n);
      for (int k = 0; k < n; k++)
         file_bytes.push_back(w[8*k +: 8]);
   endfunction

   function automatic void add_noise(int n);
      for (int k = 0; k < n; k++)
         file_bytes.push_back(8'($urandom));
   endfunction

   function automatic void add_fmt(logic [15:0] code, logic [15:0] chans, logic [31:0] rate,
                                   logic [15:0] bits, int len);
      logic [127:0] img;
      img = {bits, 16'($urandom), $urandom, rate, chans, code};
      add_word(whp_pkg::TAG_FMT, 4);
      add_word(32'(len), 4);
      for (int k = 0; k < len; k++)
         file_bytes.push_back((k < 16) ? img[8*k +: 8] : 8'($urandom));
      add_noise(len % 2);
   endfunction

   function automatic void add_data(int len);
      add_word(whp_pkg::TAG_DATA, 4);
      add_word(32'(len), 4);
      add_noise(len + len % 2);
   endfunction

   function automatic void add_junk();
      int len;
      len = $urandom_range(0, 9);
      add_word($urandom, 4);
      add_word(32'(len), 4);
      add_noise(len + len % 2);
   endfunction

   function automatic void build_file(file_kind_type kind);
      int          chans;
      int          data_len;
      int          fmt_len;
      int          spot;
      int          cut;
      logic [15:0] code;
      logic [15:0] ch16;
      logic [15:0] bits;
      logic        fmt_first;
      logic        plain_tail;
      file_bytes.delete();
      if (kind == WF_NOISE) begin
         add_noise($urandom_range(1, 20));
         return;
      end
      chans = $urandom_range(1, 2);
      code = 16'd1;
      ch16 = 16'(chans);
      bits = 16'd16;
      fmt_len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 21) : 16;
      data_len = ($urandom_range(0, 31) == 0) ? $urandom_range(60, 300)
                                               : $urandom_range(2 * chans, 16);
      fmt_first = ($urandom_range(0, 3) != 0);
      plain_tail = 1'b1;
      case (kind)
         WF_FMT_SHORT: fmt_len = $urandom_range(0, 15);
         WF_DATA_SMALL: data_len = $urandom_range(0, 2 * chans - 1);
         WF_UNSUPPORTED: begin
            case ($urandom_range(0, 2))
               0: begin
                  code = 16'($urandom);
                  if (code == 16'd1)
                     code = 16'd3;
               end
               1: begin
                  ch16 = ($urandom_range(0, 1) == 1) ? 16'd0 : 16'($urandom);
                  if (ch16 == 16'd1 || ch16 == 16'd2)
                     ch16 = 16'd3;
               end
               default: begin
                  bits = 16'($urandom);
                  if (bits == 16'd16)
                     bits = 16'd8;
               end
            endcase
         end
         WF_PAD_GONE: begin
            // odd data chunk last, file ends before its pad byte
            data_len = data_len | 1;
            fmt_first = 1'b1;
            plain_tail = 1'b0;
         end
         default: ;
      endcase
      add_word(whp_pkg::TAG_RIFF, 4);
      add_word($urandom, 4);
      add_word(whp_pkg::TAG_WAVE, 4);
      if ($urandom_range(0, 2) == 0)
         add_junk();
      if (!fmt_first && kind != WF_NO_DATA)
         add_data(data_len);
      if (kind != WF_NO_FMT) begin
         // an earlier fmt chunk that the later one replaces
         if ($urandom_range(0, 5) == 0)
            add_fmt(16'($urandom), 16'($urandom), $urandom, 16'($urandom), 16);
         add_fmt(code, ch16, $urandom, bits, fmt_len);
      end
      if (plain_tail && $urandom_range(0, 3) == 0)
         add_junk();
      if (fmt_first && kind != WF_NO_DATA) begin
         if ($urandom_range(0, 5) == 0)
            add_data($urandom_range(0, 8));
         add_data(data_len);
      end
      if (plain_tail)
         add_noise(($urandom_range(0, 7) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 7));
      else
         void'(file_bytes.pop_back());
      if (kind == WF_BAD_MAGIC) begin
         spot = $urandom_range(0, 7);
         if (spot >= 4)
            spot += 4;
         file_bytes[spot] ^= 8'($urandom_range(1, 255));
      end
      if (kind == WF_CUT) begin
         cut = $urandom_range(1, file_bytes.size() - 1);
         while (file_bytes.size() > cut)
            void'(file_bytes.pop_back());
      end
   endfunction

   // one request per byte, final byte marked, in bursts with random gaps unless no_gaps is set
   task automatic send_file();
      for (int i = 0; i < file_bytes.size(); i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!no_gaps) begin
               req_valid <= 1'b0;
               req_file_byte <= 8'($urandom);
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
         burst_left--;
         req_valid <= 1'b1;
         req_file_byte <= file_bytes[i];
         req_is_last <= (i == file_bytes.size() - 1);
         @(posedge clock);
         while (req_stall)
            @(posedge clock);
         bytes_sent++;
      end
      files_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0)
         @(posedge clock);
   endtask

   initial begin
      file_kind_type kind;
      int            pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      file_bytes = {8'hff};
      send_file();
      file_bytes = {8'h00};
      send_file();
      // short file that already broke the magic
      file_bytes.delete();
      add_word(32'h0000_0000, 4);
      add_noise(7);
      send_file();
      kind = kind.first();
      do begin
         build_file(kind);
         send_file();
         kind = kind.next();
      end while (kind != kind.first());
      drain_results();

      while (bytes_sent < BYTE_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)      kind = WF_GOOD;
         else if (pick < 55) kind = WF_CUT;
         else if (pick < 60) kind = WF_BAD_MAGIC;
         else if (pick < 67) kind = WF_FMT_SHORT;
         else if (pick < 72) kind = WF_NO_FMT;
         else if (pick < 77) kind = WF_NO_DATA;
         else if (pick < 85) kind = WF_UNSUPPORTED;
         else if (pick < 90) kind = WF_DATA_SMALL;
         else if (pick < 95) kind = WF_PAD_GONE;
         else                kind = WF_NOISE;
         build_file(kind);
         send_file();
         no_gaps = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 15) == 0)
            drain_results();
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* wav_header_parser.f */
sv/whp_pkg.sv
sv/whp_parser.sv
sv/whp_rsp_reg.sv
sv/wav_header_parser.sv
dv/wav_header_checker.sv
dv/tb_wav_header_parser.sv
